// File: sv/frt_pkg.sv
// shared constants for the fragment reassembly tracker
package frt_pkg;
    localparam int DEF_MAX_PENDING   = 8;
    localparam int DEF_MAX_FRAGMENTS = 16;

    localparam logic [31:0] TIMEOUT_RST   = 32'd1000;
    localparam logic [23:0] MAX_TOTAL_RST = 24'd1048576;
    localparam logic [15:0] MAX_FRAG_RST  = 16'd1200;

    localparam logic [1:0] REG_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_MAX_TOTAL = 2'd1;
    localparam logic [1:0] REG_MAX_FRAG  = 2'd2;

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;

    localparam logic [2:0] DR_NONE     = 3'd0;
    localparam logic [2:0] DR_TYPE     = 3'd1;
    localparam logic [2:0] DR_META     = 3'd2;
    localparam logic [2:0] DR_SIZE     = 3'd3;
    localparam logic [2:0] DR_CONFLICT = 3'd4;
endpackage

// File: sv/frt_ram.sv
// generic single-port-write ram with registered read
module frt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/fragment_reassembly_tracker_core.sv
// top level of the fragment reassembly tracker
// usage: raise start with one fragment item while busy is low; the item is
// taken at that edge and busy stays high until its last result is shown.
// results appear one per cycle, each marked by out_valid for one cycle,
// and the final one has last set; the receiver cannot stall them.
// configuration goes through cfg_valid/cfg_ready with cfg_index/cfg_data;
// the user writes it only while the block is idle; the block does not check.
// a clear, drop or pass through goes from the check state straight to the
// one-result state. a multi-fragment item walks the slot table with one
// shared compare unit, one slot per cycle: one pass for expiry, one for
// lookup, a free-slot scan that ends at the first free slot (or at once
// on a lookup hit), then apply; a non-completing add adds one eviction
// pass (at most one slot can overflow); on completion one result per
// fragment is read from the length ram, one per cycle.
// reset clears all slot valid bits and loads register defaults; slot
// contents and the length ram hold garbage until written.
module fragment_reassembly_tracker_core
    import frt_pkg::*;
#(
    parameter int MAX_PENDING   = DEF_MAX_PENDING,
    parameter int MAX_FRAGMENTS = DEF_MAX_FRAGMENTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic        is_video,
    input  logic [31:0] client_id,
    input  logic [31:0] frame_id,
    input  logic [15:0] fragment_count,
    input  logic [15:0] fragment_index,
    input  logic [15:0] payload_length,
    input  logic [31:0] now_ms,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        out_valid,
    output logic [1:0]  status,
    output logic [2:0]  drop_reason,
    output logic        passthrough,
    output logic [3:0]  slot,
    output logic [3:0]  frag_index,
    output logic [15:0] frag_length,
    output logic [23:0] total_length,
    output logic        last
);
    localparam int NSLOTS = MAX_PENDING + 1;
    localparam int SW     = $clog2(NSLOTS + 1);
    localparam int FW     = $clog2(MAX_FRAGMENTS);
    localparam int CW     = $clog2(MAX_FRAGMENTS + 1);
    localparam int DEPTH  = NSLOTS * MAX_FRAGMENTS;
    localparam int AW     = $clog2(DEPTH);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_CHECK  = 10'b0000000010,
        S_EXPIRE = 10'b0000000100,
        S_LOOK   = 10'b0000001000,
        S_FREE   = 10'b0000010000,
        S_APPLY  = 10'b0000100000,
        S_EVICT  = 10'b0001000000,
        S_RD     = 10'b0010000000,
        S_EMIT   = 10'b0100000000,
        S_ONE    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] timeout_reg;
    logic [23:0] max_total_reg;
    logic [15:0] max_frag_reg;

    logic [NSLOTS-1:0] valid_reg;
    logic [63:0]       key_reg   [NSLOTS];
    logic [CW-1:0]     cnt_reg   [NSLOTS];
    logic [MAX_FRAGMENTS-1:0] map_reg [NSLOTS];
    logic [CW-1:0]     rcv_reg   [NSLOTS];
    logic [23:0]       tot_reg   [NSLOTS];
    logic [31:0]       upd_reg   [NSLOTS];

    logic        i_func_reg, i_video_reg;
    logic [63:0] i_key_reg;
    logic [15:0] i_cnt_reg, i_idx_reg, i_len_reg;
    logic [31:0] i_now_reg;

    logic [SW-1:0] ptr_reg;
    logic [SW-1:0] hit_reg;
    logic          found_reg;
    logic [SW-1:0] old_reg;
    logic [SW-1:0] used_reg;
    logic [CW-1:0] emit_reg;
    logic [SW-1:0] es_reg;
    logic [1:0]    o_st_reg;
    logic [2:0]    o_dr_reg;
    logic          o_pass_reg;
    logic [15:0]   o_len_reg;

    logic [SW-1:0] p;
    assign p = ptr_reg;
    logic [SW-1:0] pi;
    assign pi = p;

    // shared compare unit: one slot per cycle
    logic [31:0] cmp_a, cmp_b;
    logic        cmp_gt;
    always_comb
    begin
        cmp_a = 32'd0;
        cmp_b = 32'd0;
        if (state_reg == S_EXPIRE)
        begin
            cmp_a = i_now_reg - upd_reg[pi];
            cmp_b = timeout_reg;
        end
        else
        begin
            cmp_a = upd_reg[old_reg];
            cmp_b = upd_reg[pi];
        end
        cmp_gt = cmp_a > cmp_b;
    end

    logic [47:0] prod;
    assign prod = 48'(i_cnt_reg) * 48'(max_frag_reg);
    logic [24:0] newtot;
    assign newtot = 25'(tot_reg[hit_reg]) + 25'(i_len_reg);
    logic pass_ok;
    assign pass_ok = !i_func_reg && i_video_reg && i_cnt_reg == 16'd1
                     && i_idx_reg == 16'd0 && prod <= 48'(max_total_reg);

    logic           ram_we;
    logic [AW-1:0]  ram_wa, ram_ra;
    logic [15:0]    ram_rd;
    assign ram_wa = AW'(32'(hit_reg) * MAX_FRAGMENTS + 32'(i_idx_reg[FW-1:0]));
    assign ram_ra = AW'(32'(es_reg) * MAX_FRAGMENTS + 32'(emit_reg));

    frt_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_len (
        .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(i_len_reg),
        .raddr(ram_ra), .rdata(ram_rd)
    );

    logic last_slot;
    assign last_slot = (p == SW'(NSLOTS - 1));

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RST;
            max_total_reg <= MAX_TOTAL_RST;
            max_frag_reg  <= MAX_FRAG_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TIMEOUT:   timeout_reg   <= cfg_data;
                REG_MAX_TOTAL: max_total_reg <= cfg_data[23:0];
                REG_MAX_FRAG:  max_frag_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            i_func_reg  <= func;
            i_video_reg <= is_video;
            i_key_reg   <= {client_id, frame_id};
            i_cnt_reg   <= fragment_count;
            i_idx_reg   <= fragment_index;
            i_len_reg   <= payload_length;
            i_now_reg   <= now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= '0;
            ptr_reg    <= '0;
            hit_reg    <= '0;
            found_reg  <= 1'b0;
            old_reg    <= '0;
            used_reg   <= '0;
            emit_reg   <= '0;
            es_reg     <= '0;
            o_st_reg   <= ST_IDLE;
            o_dr_reg   <= DR_NONE;
            o_pass_reg <= 1'b0;
            o_len_reg  <= '0;
            out_valid  <= 1'b0;
            status     <= ST_IDLE;
            drop_reason <= DR_NONE;
            passthrough <= 1'b0;
            slot       <= '0;
            frag_index <= '0;
            frag_length <= '0;
            total_length <= '0;
            last       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid <= (state_reg == S_EMIT) || (state_reg == S_ONE);
            unique case (state_reg)
                S_IDLE:
                begin
                    ptr_reg <= '0;
                end
                S_CHECK:
                begin
                    ptr_reg    <= '0;
                    found_reg  <= 1'b0;
                    used_reg   <= '0;
                    o_pass_reg <= pass_ok;
                    o_len_reg  <= pass_ok ? i_len_reg : '0;
                    if (i_func_reg)
                    begin
                        valid_reg <= '0;
                        o_st_reg  <= ST_IDLE;
                        o_dr_reg  <= DR_NONE;
                    end
                    else if (!i_video_reg)
                    begin
                        o_st_reg <= ST_DROPPED;
                        o_dr_reg <= DR_TYPE;
                    end
                    else if (i_cnt_reg == 16'd0 || i_idx_reg >= i_cnt_reg
                             || i_cnt_reg > 16'(MAX_FRAGMENTS))
                    begin
                        o_st_reg <= ST_DROPPED;
                        o_dr_reg <= DR_META;
                    end
                    else if (prod > 48'(max_total_reg))
                    begin
                        o_st_reg <= ST_DROPPED;
                        o_dr_reg <= DR_SIZE;
                    end
                    else if (i_cnt_reg == 16'd1)
                    begin
                        o_st_reg <= ST_COMPLETE;
                        o_dr_reg <= DR_NONE;
                    end
                    else
                    begin
                        o_st_reg <= ST_IDLE;
                        o_dr_reg <= DR_NONE;
                    end
                end
                S_EXPIRE:
                begin
                    if (valid_reg[pi] && cmp_gt)
                    begin
                        valid_reg[pi] <= 1'b0;
                    end
                    ptr_reg <= last_slot ? '0 : p + 1'b1;
                end
                S_LOOK:
                begin
                    if (!found_reg && valid_reg[pi] && key_reg[pi] == i_key_reg)
                    begin
                        found_reg <= 1'b1;
                        hit_reg   <= p;
                    end
                    ptr_reg <= last_slot ? '0 : p + 1'b1;
                end
                S_FREE:
                begin
                    if (!found_reg && !valid_reg[pi])
                    begin
                        found_reg <= 1'b1;
                        hit_reg   <= p;
                    end
                    if (last_slot && !found_reg && valid_reg[pi])
                    begin
                        found_reg <= 1'b1;
                        hit_reg   <= SW'(MAX_PENDING);
                    end
                    ptr_reg <= last_slot ? '0 : p + 1'b1;
                    if (last_slot || (!found_reg && !valid_reg[pi]))
                    begin
                        if (!found_reg)
                        begin
                            valid_reg[last_slot && valid_reg[pi] ?
                                      MAX_PENDING : pi] <= 1'b1;
                        end
                    end
                end
                S_APPLY:
                begin
                    ptr_reg  <= '0;
                    used_reg <= '0;
                    old_reg  <= '0;
                    found_reg <= 1'b0;
                    if (cnt_reg[hit_reg] != CW'(i_cnt_reg))
                    begin
                        valid_reg[hit_reg] <= 1'b0;
                        o_st_reg <= ST_DROPPED;
                        o_dr_reg <= DR_CONFLICT;
                    end
                    else if (map_reg[hit_reg][i_idx_reg[FW-1:0]])
                    begin
                    end
                    else if (newtot > 25'(max_total_reg))
                    begin
                        valid_reg[hit_reg] <= 1'b0;
                        o_st_reg <= ST_DROPPED;
                        o_dr_reg <= DR_SIZE;
                    end
                    else if (rcv_reg[hit_reg] + 1'b1 == cnt_reg[hit_reg])
                    begin
                        valid_reg[hit_reg] <= 1'b0;
                        es_reg   <= hit_reg;
                        emit_reg <= '0;
                    end
                end
                S_EVICT:
                begin
                    if (valid_reg[pi])
                    begin
                        used_reg <= used_reg + 1'b1;
                        if (!found_reg || cmp_gt)
                        begin
                            old_reg <= p;
                        end
                        found_reg <= 1'b1;
                    end
                    ptr_reg <= last_slot ? '0 : p + 1'b1;
                end
                S_RD:
                begin
                    emit_reg <= emit_reg + 1'b1;
                end
                S_EMIT:
                begin
                    status       <= ST_COMPLETE;
                    drop_reason  <= DR_NONE;
                    passthrough  <= 1'b0;
                    slot         <= 4'(es_reg);
                    frag_index   <= 4'(emit_reg - 1'b1);
                    frag_length  <= ram_rd;
                    total_length <= tot_reg[es_reg];
                    last         <= (emit_reg == cnt_reg[es_reg]);
                    emit_reg     <= emit_reg + 1'b1;
                end
                S_ONE:
                begin
                    status       <= o_st_reg;
                    drop_reason  <= o_dr_reg;
                    passthrough  <= o_pass_reg;
                    slot         <= '0;
                    frag_index   <= '0;
                    frag_length  <= o_len_reg;
                    total_length <= 24'(o_len_reg);
                    last         <= 1'b1;
                    if (state_next == S_IDLE && used_reg > SW'(MAX_PENDING))
                    begin
                        valid_reg[old_reg] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // slot contents: written on new key and on apply
    logic new_slot;
    assign new_slot = (state_reg == S_FREE) && !found_reg
                      && (!valid_reg[pi] || last_slot);
    always_ff @(posedge clk)
    begin
        if (new_slot)
        begin
            key_reg[valid_reg[pi] ? MAX_PENDING : pi] <= i_key_reg;
            cnt_reg[valid_reg[pi] ? MAX_PENDING : pi] <= CW'(i_cnt_reg);
            map_reg[valid_reg[pi] ? MAX_PENDING : pi] <= '0;
            rcv_reg[valid_reg[pi] ? MAX_PENDING : pi] <= '0;
            tot_reg[valid_reg[pi] ? MAX_PENDING : pi] <= '0;
            upd_reg[valid_reg[pi] ? MAX_PENDING : pi] <= i_now_reg;
        end
        if (state_reg == S_APPLY
            && cnt_reg[hit_reg] == CW'(i_cnt_reg))
        begin
            upd_reg[hit_reg] <= i_now_reg;
            if (!map_reg[hit_reg][i_idx_reg[FW-1:0]]
                && newtot <= 25'(max_total_reg))
            begin
                map_reg[hit_reg][i_idx_reg[FW-1:0]] <= 1'b1;
                rcv_reg[hit_reg] <= rcv_reg[hit_reg] + 1'b1;
                tot_reg[hit_reg] <= newtot[23:0];
            end
        end
    end

    logic completing;
    assign completing = (cnt_reg[hit_reg] == CW'(i_cnt_reg))
                        && !map_reg[hit_reg][i_idx_reg[FW-1:0]]
                        && newtot <= 25'(max_total_reg)
                        && (rcv_reg[hit_reg] + 1'b1 == cnt_reg[hit_reg]);
    logic adding;
    assign adding = (cnt_reg[hit_reg] == CW'(i_cnt_reg))
                    && !map_reg[hit_reg][i_idx_reg[FW-1:0]]
                    && newtot <= 25'(max_total_reg);

    assign ram_we = (state_reg == S_APPLY) && adding;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (start) state_next = S_CHECK;
            S_CHECK:
            begin
                if (i_func_reg || !i_video_reg || i_cnt_reg <= 16'd1
                    || i_idx_reg >= i_cnt_reg || i_cnt_reg > 16'(MAX_FRAGMENTS)
                    || prod > 48'(max_total_reg))
                    state_next = S_ONE;
                else
                    state_next = S_EXPIRE;
            end
            S_EXPIRE: if (last_slot) state_next = S_LOOK;
            S_LOOK:   if (last_slot) state_next = S_FREE;
            S_FREE:   if (last_slot || found_reg) state_next = S_APPLY;
            S_APPLY:
            begin
                if (completing)   state_next = S_RD;
                else if (adding)  state_next = S_EVICT;
                else              state_next = S_ONE;
            end
            S_EVICT:  if (last_slot) state_next = S_ONE;
            S_RD:     state_next = S_EMIT;
            S_EMIT:
            begin
                if (emit_reg == cnt_reg[es_reg]) state_next = S_IDLE;
            end
            S_ONE:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // free scan skips to apply when lookup already hit
    // (found_reg set in look keeps free from allocating)

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |=> out_valid)
        else $error("emit run broken");
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("item not taken");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && passthrough |-> last && status == ST_COMPLETE)
        else $error("bad pass through result");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_DROPPED |-> last && drop_reason != DR_NONE)
        else $error("bad drop result");
endmodule
